// ===== hw/rtl/mavg_pkg.sv =====
// Shared widths, defaults and controller/datapath interface types for the moving average.
package mavg_pkg;

  localparam int SAMPLE_W       = 48;
  localparam int SUM_W          = 56;
  localparam int WLEN_W         = 8;
  localparam int DEF_MAX_WINDOW = 128;
  localparam int CNT_W          = $clog2(SUM_W);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;      // config write: load window length, clear history
    logic accept;     // input transaction: write ring, add sample
    logic evict;      // subtract the evicted ring entry
    logic div_start;  // load the divider with |sum|
    logic div_step;   // one restoring-division step
    logic load_out;   // drive the quotient into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_last;   // current division step is the final one
  } sts_t;

endpackage

// ===== hw/rtl/mavg_ctrl.sv =====
// Sequencer for the moving average: handshakes and command generation.
module mavg_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  output mavg_pkg::cmd_t  cmd,
  input  mavg_pkg::sts_t  sts
);
  import mavg_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    EVICT,
    LOAD,
    DIV,
    DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Output register can take a new result when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  // Decode next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      IDLE: begin
        cmd.clear = cfg_valid;
        if (in_valid && !cfg_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = EVICT;
        end
      end
      EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = LOAD;
      end
      LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt     = DIV;
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = DONE;
        end
      end
      DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != IDLE) || cfg_valid;
  assign cfg_ready = (state_r == IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/mavg_dp.sv =====
// Datapath for the moving average: sample ring, running sum, fill count and divider.
module mavg_dp #(
  parameter int MAX_WINDOW = mavg_pkg::DEF_MAX_WINDOW
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mavg_pkg::cmd_t                  cmd,
  output mavg_pkg::sts_t                  sts,
  input  logic [mavg_pkg::WLEN_W-1:0]     cfg_window_length,
  input  logic signed [mavg_pkg::SAMPLE_W-1:0] in_sample,
  output logic signed [mavg_pkg::SAMPLE_W-1:0] out_average
);
  import mavg_pkg::*;

  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  // Ring memory
  logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];
  logic [SAMPLE_W-1:0] evict_r;
  logic                evict_zero_r;

  // Control state
  logic [WLEN_W-1:0] wlen_r, wlen_nxt;
  logic [WLEN_W-1:0] fill_r;
  logic [PTR_W-1:0]  ptr_r;
  logic [PTR_W:0]    ptr_inc;
  logic [SUM_W-1:0]  sum_r;

  // Divider
  logic [SUM_W-1:0]  quot_r;
  logic [WLEN_W-1:0] rem_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WLEN_W:0]   rem_shift;
  logic [WLEN_W:0]   rem_diff;
  logic              take;
  logic [SUM_W-1:0]  sum_abs;
  logic [SUM_W-1:0]  sample_ext;
  logic [SUM_W-1:0]  evict_ext;
  logic [SAMPLE_W-1:0] out_average_r;

  // Clamp the written window length to 1..MAX_WINDOW
  always_comb begin
    if (cfg_window_length == '0) begin
      wlen_nxt = WLEN_W'(1);
    end else if (int'(cfg_window_length) > MAX_WINDOW) begin
      wlen_nxt = WLEN_W'(MAX_WINDOW);
    end else begin
      wlen_nxt = cfg_window_length;
    end
  end

  assign ptr_inc    = (PTR_W + 1)'(ptr_r) + (PTR_W + 1)'(1);
  assign sample_ext = {{(SUM_W - SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample};
  assign evict_ext  = evict_zero_r ? '0 :
                      {{(SUM_W - SAMPLE_W){evict_r[SAMPLE_W-1]}}, evict_r};
  assign sum_abs    = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;

  // Restoring division step: divisor is the fill count
  assign rem_shift = {rem_r, quot_r[SUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, fill_r};
  assign take      = (rem_shift >= {1'b0, fill_r});

  assign sts.div_last = (cnt_r == CNT_W'(SUM_W - 1));

  // Write the new sample, read the evicted one (old data on the same address)
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring_mem[ptr_r] <= in_sample;
      evict_r         <= ring_mem[ptr_r];
      evict_zero_r    <= (fill_r < wlen_r);
    end
  end

  // Window length, fill count, pointer and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= WLEN_W'(1);
      fill_r <= '0;
      ptr_r  <= '0;
      sum_r  <= '0;
    end else if (cmd.clear) begin
      wlen_r <= wlen_nxt;
      fill_r <= '0;
      ptr_r  <= '0;
      sum_r  <= '0;
    end else if (cmd.accept) begin
      sum_r <= sum_r + sample_ext;
      if (ptr_inc >= (PTR_W + 1)'(wlen_r)) begin
        ptr_r <= '0;
      end else begin
        ptr_r <= ptr_inc[PTR_W-1:0];
      end
      if (fill_r < wlen_r) begin
        fill_r <= fill_r + WLEN_W'(1);
      end
    end else if (cmd.evict) begin
      sum_r <= sum_r - evict_ext;
    end
  end

  // Divider registers: magnitude in, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quot_r <= sum_abs;
      rem_r  <= '0;
      neg_r  <= sum_r[SUM_W-1];
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      quot_r <= {quot_r[SUM_W-2:0], take};
      rem_r  <= take ? rem_diff[WLEN_W-1:0] : rem_shift[WLEN_W-1:0];
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

  // Output register: restore the sign, truncation toward zero
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_average_r <= neg_r ? (~quot_r[SAMPLE_W-1:0] + SAMPLE_W'(1))
                             : quot_r[SAMPLE_W-1:0];
    end
  end

  assign out_average = out_average_r;

endmodule

// ===== hw/rtl/moving_average_filter.sv =====
// Top level of the simple moving average filter over signed 48-bit time samples.
// Each accepted sample replaces the oldest of the last window_length samples and
// yields one average, the running sum divided by the number of samples held,
// truncated toward zero. After acceptance the block stays busy through the ring
// read, the eviction subtract, the divider load, the restoring divider at one
// quotient bit per cycle, and the result hand-off, held off by a stalled result.
// A finished result waits in the output register while the next sample is taken.
// Writing window_length (0 counts as 1, values above MAX_WINDOW saturate) clears
// the history, the sum and the fill count; write it only while the block is idle.
module moving_average_filter #(
  parameter int MAX_WINDOW = mavg_pkg::DEF_MAX_WINDOW
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mavg_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mavg_pkg::SAMPLE_W-1:0] out_average,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mavg_pkg::WLEN_W-1:0]          cfg_window_length
);
  import mavg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  mavg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Ring, sum and divider
  mavg_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_window_length (cfg_window_length),
    .in_sample         (in_sample),
    .out_average       (out_average)
  );

endmodule

// ===== hw/rtl/mavg_checker.sv =====
// Port-level assertions for the moving average filter, bound to the top level.
module mavg_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [mavg_pkg::SAMPLE_W-1:0] out_average,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready
);

  // A stalled result keeps its valid and its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_average))
    else $error("stalled result changed");

  // An accepted transaction makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in consecutive cycles");

  // Configuration is only offered while the input side is idle
  a_cfg_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready && !cfg_valid |-> !in_stall)
    else $error("config ready while input busy");

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind moving_average_filter mavg_checker u_mavg_checker (.*);

// ===== tb/moving_average_filter_tb.sv =====
// Self-checking testbench for the moving average filter: scoreboard class, drivers and checks.
`timescale 1ns / 1ps

module moving_average_filter_tb;
  import mavg_pkg::*;

  localparam int RING_DEPTH = DEF_MAX_WINDOW;
  localparam logic signed [SAMPLE_W-1:0] MAX_SAMPLE = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] MIN_SAMPLE = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam int RANDOM_SAMPLES = 2000;

  // Tracks the window history and holds the averages still owed by the filter
  class mavg_scoreboard;
    logic signed [SAMPLE_W-1:0] history [RING_DEPTH];
    longint running_total;
    int unsigned held;
    int unsigned slot;
    int unsigned span;
    logic signed [SAMPLE_W-1:0] owed_averages [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      errors = 0;
      checked = 0;
      span = 1;
      clear_history();
    endfunction

    function void clear_history();
      foreach (history[i]) history[i] = '0;
      running_total = 0;
      held = 0;
      slot = 0;
    endfunction

    // Saturate the written length into 1..RING_DEPTH and drop all history
    function void note_window(logic [WLEN_W-1:0] len);
      if (len == 0) span = 1;
      else if (len > RING_DEPTH) span = RING_DEPTH;
      else span = len;
      clear_history();
    endfunction

    // Replace the oldest entry and work out the new average
    function void note_sample(logic signed [SAMPLE_W-1:0] x);
      int unsigned p;
      longint quotient;
      p = slot;
      if (p >= span) p = 0;
      running_total = running_total - longint'(history[p]) + longint'(x);
      history[p] = x;
      p = p + 1;
      if (p >= span) p = 0;
      slot = p;
      if (held < span) held++;
      quotient = running_total / longint'(held);
      owed_averages.push_back(quotient[SAMPLE_W-1:0]);
    endfunction

    function void check_average(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (owed_averages.size() == 0) begin
        $display("%0t: average %0d arrived with none expected", $time, got);
        errors++;
        return;
      end
      want = owed_averages.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: average mismatch, expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_averages.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic out_valid;
  logic out_stall;
  logic signed [SAMPLE_W-1:0] out_average;
  logic cfg_valid;
  logic cfg_ready;
  logic [WLEN_W-1:0] cfg_window_length;

  mavg_scoreboard sb;
  bit steady;
  int unsigned samples_sent;
  int unsigned window_writes;

  moving_average_filter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_average      (out_average),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_window_length(cfg_window_length)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Stall the result channel now and then, never during the steady stretch
  always @(negedge clk) begin
    out_stall <= rst_n && !steady && ($urandom_range(0, 99) < 9);
  end

  // Check every average transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_average(out_average);
    end
  end

  // Offer one sample, after an optional gap, and hold it until taken
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    if (!steady) begin
      while ($urandom_range(0, 99) < 9) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid  <= 1'b1;
    in_sample <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(x);
    samples_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed average is out
  task automatic drain_averages();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_window(input logic [WLEN_W-1:0] len);
    drain_averages();
    cfg_valid         <= 1'b1;
    cfg_window_length <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_window(len);
    window_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mix of extremes, near-extremes, small values and full-width random samples
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [63:0] r;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    r = {$urandom, $urandom};
    case (mode)
      0: return MAX_SAMPLE;
      1: return MIN_SAMPLE;
      2: return SAMPLE_W'($signed($urandom_range(0, 200)) - 100);
      3: return MAX_SAMPLE - SAMPLE_W'($urandom_range(0, 1000));
      4: return MIN_SAMPLE + SAMPLE_W'($urandom_range(0, 1000));
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  initial begin
    logic [WLEN_W-1:0] len;
    int unsigned span;
    int unsigned phase_len;
    int unsigned random_start;
    bit paused;

    sb = new();
    steady = 1'b0;
    paused = 1'b0;
    samples_sent = 0;
    window_writes = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_window_length = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset window of one: each sample is its own average
    send_sample(MAX_SAMPLE);
    send_sample(MIN_SAMPLE);
    send_sample('0);
    send_sample(-48'sd1);
    send_sample(48'sd1);

    // Zero length behaves as one
    write_window('0);
    send_sample(48'sd12345);

    // Window of two: extremes cancel, odd negative sums truncate toward zero
    write_window(8'd2);
    send_sample(MAX_SAMPLE);
    send_sample(MAX_SAMPLE);
    send_sample(MIN_SAMPLE);
    send_sample(MIN_SAMPLE);
    send_sample(-48'sd7);
    send_sample('0);
    send_sample(48'sd3);

    // Window of three while it fills and then wraps
    write_window(8'd3);
    send_sample(48'sd1);
    send_sample(48'sd2);
    send_sample(48'sd2);
    send_sample(-48'sd1);
    send_sample(-48'sd2);
    send_sample(-48'sd2);

    // Lengths above the maximum saturate
    write_window(8'hFF);
    send_sample(MIN_SAMPLE);
    send_sample(MIN_SAMPLE);
    send_sample(MAX_SAMPLE);
    write_window(8'd129);
    send_sample(MAX_SAMPLE);
    send_sample(-48'sd5);

    // Random phases, each under a fresh window length
    random_start = samples_sent;
    while (samples_sent - random_start < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 7))
        0: len = 8'd1;
        1: len = 8'd2;
        2: len = 8'd3;
        3: len = 8'd128;
        4: len = 8'd0;
        5: len = 8'd255;
        6: len = 8'd129;
        default: len = WLEN_W'($urandom_range(0, 255));
      endcase
      write_window(len);
      span = (len == 0) ? 1 : ((len > RING_DEPTH) ? RING_DEPTH : len);
      phase_len = (span >= 64) ? $urandom_range(150, 300) : $urandom_range(40, 200);
      repeat (phase_len) begin
        steady = (samples_sent - random_start >= 700) && (samples_sent - random_start < 1000);
        if (!paused && samples_sent - random_start >= 500) begin
          // Let the filter run dry once in the middle of a phase
          drain_averages();
          paused = 1'b1;
        end
        send_sample(pick_sample());
      end
    end
    steady = 1'b0;

    drain_averages();
    repeat (100) @(negedge clk);

    $display("summary: %0d samples sent, %0d averages checked, %0d window writes",
             samples_sent, sb.checked, window_writes);
    $display("summary: lengths 0 to 255 incl. saturation, full-scale samples, wraparound");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mavg_pkg.sv
hw/rtl/mavg_ctrl.sv
hw/rtl/mavg_dp.sv
hw/rtl/moving_average_filter.sv
hw/rtl/mavg_checker.sv
tb/moving_average_filter_tb.sv
